// File: design/hrmb_pkg.sv
// Shared types, constants and usage table for the HID report to make/break converter.
package hrmb_pkg;

    localparam int KEYS_PER_REPORT = 6;
    localparam int KEY_BYTE_OFFSET = 2;
    localparam int NUM_MODS        = 8;
    localparam int NUM_SLOTS       = NUM_MODS + 2 * KEYS_PER_REPORT;
    localparam int KEY_W           = 9;

    localparam logic [7:0] PAUSE_USAGE   = 8'h48;
    localparam logic [7:0] MOD_CODE_BASE = 8'hE0;
    localparam logic [7:0] CTRL_MASK     = 8'h11;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [3:0] report_length;
        logic [7:0] modifier_bits;
        logic [7:0] key_usage_0;
        logic [7:0] key_usage_1;
        logic [7:0] key_usage_2;
        logic [7:0] key_usage_3;
        logic [7:0] key_usage_4;
        logic [7:0] key_usage_5;
    } report_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       ctrl_break_variant;
        logic       is_release;
        logic       last;
    } key_event_t;

    // one classified report: which event slots fire, plus the data they need
    typedef struct packed {
        logic [NUM_SLOTS-1:0]             slot_mask;
        logic [NUM_MODS-1:0]              mod_new;
        logic [KEYS_PER_REPORT-1:0][KEY_W-1:0] prev_keys;
        logic [KEYS_PER_REPORT-1:0][KEY_W-1:0] cur_keys;
    } job_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    function automatic logic usage_mapped(input logic [7:0] u);
        logic m;
        begin
            m = 1'b0;
            if (u == 8'h01 || u == 8'h02) m = 1'b1;
            if (u >= 8'h04 && u <= 8'h65) m = 1'b1;
            if (u >= 8'h67 && u <= 8'h6A) m = 1'b1;
            if (u == 8'h85) m = 1'b1;
            if (u >= 8'h87 && u <= 8'h8C) m = 1'b1;
            if (u >= 8'h90 && u <= 8'h94) m = 1'b1;
            if (u >= 8'hE0 && u <= 8'hE7) m = 1'b1;
            return m;
        end
    endfunction

endpackage

// File: design/hrmb_front.sv
// Front end: accepts reports, tracks held state and classifies the events each report causes.
module hrmb_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              report_valid,
    output logic              report_ready,
    input  hrmb_pkg::report_t report,
    output logic              push,
    output hrmb_pkg::job_t    push_job,
    input  logic              queue_full
);
    import hrmb_pkg::*;

    logic [7:0]                            held_mod_reg;
    logic [7:0]                            held_mod_next;
    logic [KEYS_PER_REPORT-1:0][KEY_W-1:0] held_keys_reg;
    logic [KEYS_PER_REPORT-1:0][KEY_W-1:0] cur;
    logic [KEYS_PER_REPORT-1:0][7:0]       usage;
    logic [NUM_SLOTS-1:0]                  mask;
    logic [7:0]                            mods_eff;
    logic                                  ctrl;
    logic                                  accept;

    assign usage[0] = report.key_usage_0;
    assign usage[1] = report.key_usage_1;
    assign usage[2] = report.key_usage_2;
    assign usage[3] = report.key_usage_3;
    assign usage[4] = report.key_usage_4;
    assign usage[5] = report.key_usage_5;

    assign report_ready = !queue_full;
    assign accept       = report_valid && report_ready;

    assign mods_eff      = (report.report_length != 4'd0) ? report.modifier_bits : held_mod_reg;
    assign held_mod_next = mods_eff;
    assign ctrl          = |(mods_eff & CTRL_MASK);

    always_comb
    begin
        logic [7:0] u;
        for (int i = 0; i < KEYS_PER_REPORT; i++)
        begin
            u = (report.report_length > 4'(KEY_BYTE_OFFSET + i)) ? usage[i] : 8'd0;
            if (usage_mapped(u))
                cur[i] = {(u == PAUSE_USAGE) && ctrl, u};
            else
                cur[i] = '0;
        end
    end

    always_comb
    begin
        logic still;
        logic was;
        mask = '0;
        if (report.report_length != 4'd0)
            mask[NUM_MODS-1:0] = report.modifier_bits ^ held_mod_reg;
        for (int i = 0; i < KEYS_PER_REPORT; i++)
        begin
            still = 1'b0;
            was   = 1'b0;
            for (int j = 0; j < KEYS_PER_REPORT; j++)
            begin
                if (cur[j] == held_keys_reg[i]) still = 1'b1;
                if (held_keys_reg[j] == cur[i]) was = 1'b1;
            end
            // the break variant of pause never releases
            mask[NUM_MODS + 2*i] = (held_keys_reg[i] != '0) && !still
                                   && !held_keys_reg[i][KEY_W-1];
            mask[NUM_MODS + 2*i + 1] = (cur[i] != '0) && !was;
        end
    end

    assign push               = accept && (|mask);
    assign push_job.slot_mask = mask;
    assign push_job.mod_new   = mods_eff;
    assign push_job.prev_keys = held_keys_reg;
    assign push_job.cur_keys  = cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_mod_reg  <= '0;
            held_keys_reg <= '0;
        end
        else if (accept)
        begin
            held_mod_reg  <= held_mod_next;
            held_keys_reg <= cur;
        end
    end

endmodule

// File: design/hrmb_fifo.sv
// Small register FIFO between front and back.
module hrmb_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr) wr_ptr_reg <= wr_ptr_next;
            if (do_rd) rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: design/hrmb_back.sv
// Back end: walks the firing event slots of one report and drives the output register.
module hrmb_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 queue_empty,
    input  hrmb_pkg::job_t       head_job,
    output logic                 pop,
    output logic                 key_event_valid,
    input  logic                 key_event_ready,
    output hrmb_pkg::key_event_t key_event
);
    import hrmb_pkg::*;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [NUM_SLOTS-1:0] mask_reg;
    logic [NUM_SLOTS-1:0] mask_next;
    logic [NUM_SLOTS-1:0] low;
    logic [NUM_SLOTS-1:0] rest;
    job_t                 job_reg;
    key_event_t           ev;
    key_event_t           out_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_free;
    logic                 emit;

    assign out_free = !out_valid_reg || key_event_ready;
    assign low      = mask_reg & (~mask_reg + 1'b1);
    assign rest     = mask_reg & ~low;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (!queue_empty) state_next = BK_RUN;
            BK_RUN:
                if (out_free && rest == '0) state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        emit = 1'b0;
        case (state_reg)
            BK_IDLE: pop  = !queue_empty;
            BK_RUN:  emit = out_free;
            default:
            begin
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ev = '0;
        for (int s = 0; s < NUM_MODS; s++)
        begin
            if (low[s])
            begin
                ev.key_code   = MOD_CODE_BASE + 8'(s);
                ev.is_release = !job_reg.mod_new[s];
            end
        end
        for (int i = 0; i < KEYS_PER_REPORT; i++)
        begin
            if (low[NUM_MODS + 2*i])
            begin
                ev.key_code   = job_reg.prev_keys[i][7:0];
                ev.is_release = 1'b1;
            end
            if (low[NUM_MODS + 2*i + 1])
            begin
                ev.key_code           = job_reg.cur_keys[i][7:0];
                ev.ctrl_break_variant = job_reg.cur_keys[i][KEY_W-1];
            end
        end
        ev.last = (rest == '0);
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (pop)
            mask_next = head_job.slot_mask;
        else if (emit)
            mask_next = rest;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (key_event_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)  job_reg <= head_job;
        if (emit) out_reg <= ev;
    end

    assign key_event_valid = out_valid_reg;
    assign key_event       = out_reg;

endmodule

// File: design/hid_report_to_make_break.sv
// Top level: HID boot keyboard report in, key make/release events out.
//
//  channel    | dir | handshake                        | beat
//  -----------+-----+----------------------------------+--------------------------
//  report     | in  | report_valid / report_ready      | one keyboard report
//  key_event  | out | key_event_valid / key_event_ready| one make or release event
//
// A report is classified in the cycle it is accepted and queued (2 entries).
// The back end loads a report from the queue, then emits its events in turn
// (up to 20), pausing while the output is stalled, and takes no new report until done.
// Reports that cause no event are absorbed and never reach the queue.
// report_ready drops only while the queue is full; a stalled output holds its beat.
// Reset clears held modifiers and held keys to empty.
module hid_report_to_make_break
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 report_valid,
    output logic                 report_ready,
    input  hrmb_pkg::report_t    report,
    output logic                 key_event_valid,
    input  logic                 key_event_ready,
    output hrmb_pkg::key_event_t key_event
);
    import hrmb_pkg::*;

    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    job_t push_job;
    job_t head_job;

    hrmb_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report       (report),
        .push         (push),
        .push_job     (push_job),
        .queue_full   (queue_full)
    );

    hrmb_fifo
    #(
        .WIDTH ($bits(job_t)),
        .DEPTH (2)
    )
    u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (push_job),
        .rd_en   (pop),
        .rd_data (head_job),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    hrmb_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_empty     (queue_empty),
        .head_job        (head_job),
        .pop             (pop),
        .key_event_valid (key_event_valid),
        .key_event_ready (key_event_ready),
        .key_event       (key_event)
    );

endmodule

// File: design/hrmb_checker.sv
// Port-level checks for the HID report to make/break converter, bound to the top level.
module hrmb_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 key_event_valid,
    input logic                 key_event_ready,
    input hrmb_pkg::key_event_t key_event
);
    import hrmb_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        key_event_valid && !key_event_ready |=> key_event_valid)
        else $error("key_event beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        key_event_valid && !key_event_ready |=> $stable(key_event))
        else $error("key_event beat changed while stalled");

    a_break_is_pause_make: assert property (@(posedge clk) disable iff (!rst_n)
        key_event_valid && key_event.ctrl_break_variant
        |-> key_event.key_code == PAUSE_USAGE && !key_event.is_release)
        else $error("break variant on a non-pause code or on a release");

    a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        key_event_valid |-> key_event.key_code != 8'd0)
        else $error("event carries an empty key code");

endmodule

bind hid_report_to_make_break hrmb_checker u_hrmb_checker (.*);

// File: tb/tb_top.sv
// Testbench for hid_report_to_make_break: directed and random reports, self-checking event scoreboard.
module tb_top;
    import hrmb_pkg::*;

    localparam int N_RANDOM    = 200;
    localparam int QUIET_TAIL  = 40;
    localparam int HOLD_AT     = 100;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 60;

    class key_event_board;
        key_event_t pending_q[$];
        logic [7:0] held_mods;
        key_t       held[KEYS_PER_REPORT];
        int         errors;

        function new();
            held_mods = '0;
            foreach (held[i]) held[i] = '0;
            errors = 0;
        endfunction

        function bit is_mapped(logic [7:0] u);
            return (u == 8'h01) || (u == 8'h02) || (u >= 8'h04 && u <= 8'h65)
                || (u >= 8'h67 && u <= 8'h6A) || (u == 8'h85)
                || (u >= 8'h87 && u <= 8'h8C) || (u >= 8'h90 && u <= 8'h94)
                || (u >= 8'hE0 && u <= 8'hE7);
        endfunction

        function void add_event(logic [7:0] code, logic brk, logic rel);
            key_event_t e;
            e.key_code           = code;
            e.ctrl_break_variant = brk;
            e.is_release         = rel;
            e.last               = 1'b0;
            pending_q.push_back(e);
        endfunction

        function void note_report(report_t r);
            int         len;
            int         first;
            bit         found;
            logic [7:0] usage[KEYS_PER_REPORT];
            key_t       cur[KEYS_PER_REPORT];
            key_event_t tail;
            first = pending_q.size();
            len   = r.report_length;
            if (len > KEY_BYTE_OFFSET + KEYS_PER_REPORT)
                len = KEY_BYTE_OFFSET + KEYS_PER_REPORT;
            usage[0] = r.key_usage_0;
            usage[1] = r.key_usage_1;
            usage[2] = r.key_usage_2;
            usage[3] = r.key_usage_3;
            usage[4] = r.key_usage_4;
            usage[5] = r.key_usage_5;
            if (len > 0)
            begin
                for (int b = 0; b < 8; b++)
                    if (held_mods[b] != r.modifier_bits[b])
                        add_event(MOD_CODE_BASE | 8'(b), 1'b0, ~r.modifier_bits[b]);
                held_mods = r.modifier_bits;
            end
            for (int i = 0; i < KEYS_PER_REPORT; i++)
            begin
                cur[i] = '0;
                if (len > KEY_BYTE_OFFSET + i && is_mapped(usage[i]))
                    cur[i] = {(usage[i] == PAUSE_USAGE) && ((held_mods & CTRL_MASK) != 0),
                              usage[i]};
            end
            for (int i = 0; i < KEYS_PER_REPORT; i++)
            begin
                if (held[i] != '0)
                begin
                    found = 1'b0;
                    for (int j = 0; j < KEYS_PER_REPORT; j++)
                        if (cur[j] == held[i]) found = 1'b1;
                    // break variant never releases
                    if (!found && !held[i][8])
                        add_event(held[i][7:0], 1'b0, 1'b1);
                end
                if (cur[i] != '0)
                begin
                    found = 1'b0;
                    for (int j = 0; j < KEYS_PER_REPORT; j++)
                        if (held[j] == cur[i]) found = 1'b1;
                    if (!found)
                        add_event(cur[i][7:0], cur[i][8], 1'b0);
                end
            end
            held = cur;
            if (pending_q.size() > first)
            begin
                tail      = pending_q.pop_back();
                tail.last = 1'b1;
                pending_q.push_back(tail);
            end
        endfunction

        function void check_event(key_event_t got);
            key_event_t want;
            if (pending_q.size() == 0)
            begin
                $error("unexpected beat: key_code %h break %b release %b last %b",
                       got.key_code, got.ctrl_break_variant, got.is_release, got.last);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.key_code !== want.key_code)
            begin
                $error("key_code: expected %h, got %h", want.key_code, got.key_code);
                errors++;
            end
            if (got.ctrl_break_variant !== want.ctrl_break_variant)
            begin
                $error("ctrl_break_variant: expected %b, got %b",
                       want.ctrl_break_variant, got.ctrl_break_variant);
                errors++;
            end
            if (got.is_release !== want.is_release)
            begin
                $error("is_release: expected %b, got %b", want.is_release, got.is_release);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %b, got %b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n           = 1'b0;
    logic       report_valid    = 1'b0;
    logic       report_ready;
    report_t    report          = '0;
    logic       key_event_valid;
    logic       key_event_ready = 1'b0;
    key_event_t key_event;

    key_event_board board;
    bit         quiet     = 1'b0;
    bit         held_off  = 1'b0;
    int         sent_count = 0;
    logic [7:0] gen_mods = '0;
    logic [7:0] gen_keys[KEYS_PER_REPORT] = '{default: 8'h00};

    hid_report_to_make_break uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .report_valid    (report_valid),
        .report_ready    (report_ready),
        .report          (report),
        .key_event_valid (key_event_valid),
        .key_event_ready (key_event_ready),
        .key_event       (key_event)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic report_t build_report(input logic [3:0] len, input logic [7:0] mods,
                                             input logic [7:0] k0, input logic [7:0] k1,
                                             input logic [7:0] k2, input logic [7:0] k3,
                                             input logic [7:0] k4, input logic [7:0] k5);
        report_t r;
        r.report_length = len;
        r.modifier_bits = mods;
        r.key_usage_0   = k0;
        r.key_usage_1   = k1;
        r.key_usage_2   = k2;
        r.key_usage_3   = k3;
        r.key_usage_4   = k4;
        r.key_usage_5   = k5;
        return r;
    endfunction

    function automatic logic [7:0] pick_usage();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return PAUSE_USAGE;
            2:       return MOD_CODE_BASE | 8'($urandom_range(0, 7));
            3:       return 8'($urandom);
            default: return 8'h04 + 8'($urandom_range(0, 15));
        endcase
    endfunction

    // mostly small edits of the previous report so keys persist and overlap
    function automatic report_t make_random_report();
        logic [7:0] k[KEYS_PER_REPORT];
        logic [7:0] mods;
        logic [7:0] spare;
        logic [3:0] len;
        if ($urandom_range(0, 19) == 0)
        begin
            len  = 4'($urandom_range(0, 15));
            mods = 8'($urandom);
            foreach (k[i]) k[i] = 8'($urandom);
        end
        else
        begin
            foreach (k[i]) k[i] = ($urandom_range(0, 3) == 0) ? pick_usage() : gen_keys[i];
            if ($urandom_range(0, 9) == 0)
            begin
                spare = k[0];
                for (int i = 0; i < KEYS_PER_REPORT - 1; i++) k[i] = k[i + 1];
                k[KEYS_PER_REPORT - 1] = spare;
            end
            mods = gen_mods;
            if ($urandom_range(0, 2) == 0) mods[$urandom_range(0, 7)] ^= 1'b1;
            if ($urandom_range(0, 4) == 0) mods[0] ^= 1'b1;
            if ($urandom_range(0, 6) == 0) mods[4] ^= 1'b1;
            len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
        end
        gen_mods = mods;
        gen_keys = k;
        return build_report(len, mods, k[0], k[1], k[2], k[3], k[4], k[5]);
    endfunction

    task automatic send_report(input report_t r);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            report_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        report_valid <= 1'b1;
        report       <= r;
        do @(posedge clk); while (!report_ready);
        board.note_report(r);
        sent_count++;
    endtask

    task automatic run_directed();
        send_report(build_report(4'd8, 8'h00, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(build_report(4'd8, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        // every modifier and every position changes: widest burst
        send_report(build_report(4'd8, 8'h00, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
        send_report(build_report(4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(build_report(4'd0, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        send_report(build_report(4'd1, 8'h11, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        send_report(build_report(4'd8, 8'h11, PAUSE_USAGE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(build_report(4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(build_report(4'd8, 8'h10, 8'h00, PAUSE_USAGE, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(build_report(4'd8, 8'h00, 8'h00, PAUSE_USAGE, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(build_report(4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(build_report(4'd8, 8'h00, 8'h1A, 8'h1A, 8'h1A, 8'h00, 8'h00, 8'h00));
        send_report(build_report(4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(build_report(4'd8, 8'h00, 8'h00, 8'h03, 8'h66, 8'h6B, 8'h84, 8'h86));
        send_report(build_report(4'd8, 8'h00, 8'h8D, 8'h95, 8'hDF, 8'hE8, 8'hFF, 8'h01));
        send_report(build_report(4'd8, 8'h00, 8'h02, 8'h65, 8'h67, 8'h6A, 8'h85, 8'h87));
        send_report(build_report(4'd8, 8'h00, 8'h8C, 8'h90, 8'h94, 8'hE0, 8'hE7, 8'h04));
        send_report(build_report(4'd4, 8'h00, 8'h8C, 8'h90, 8'h94, 8'hE0, 8'hE7, 8'h04));
        send_report(build_report(4'd15, 8'hA5, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E));
        send_report(build_report(4'd9, 8'h5A, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E));
        send_report(build_report(4'd3, 8'h5A, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E));
        send_report(build_report(4'd2, 8'h00, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E));
        send_report(build_report(4'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_report(build_report(4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    initial
    begin
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int n = 0; n < N_RANDOM; n++)
        begin
            quiet = (n >= N_RANDOM - QUIET_TAIL);
            send_report(make_random_report());
        end
        report_valid <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // event sink: random stalls plus one long hold-off to back up the input
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (key_event_valid && key_event_ready)
                board.check_event(key_event);
            if (!held_off && sent_count >= HOLD_AT)
            begin
                held_off = 1'b1;
                stall    = HOLD_CYCLES;
            end
            else if (stall == 0 && !quiet && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 11);
            if (stall > 0)
            begin
                key_event_ready <= 1'b0;
                stall--;
            end
            else
                key_event_ready <= 1'b1;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((report_valid && report_ready) || (key_event_valid && key_event_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
design/hrmb_pkg.sv
design/hrmb_front.sv
design/hrmb_fifo.sv
design/hrmb_back.sv
design/hid_report_to_make_break.sv
design/hrmb_checker.sv
tb/tb_top.sv
